// ----- design/qnp_pkg.sv -----
package qnp_pkg;

   // component format: Q1.15
   localparam int CompBits = 16;
   localparam logic signed [CompBits-1:0] IdentW = 16'sd32767;
   localparam logic [16:0] TOne = 17'd65536;

   // request codes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STEP  = 2'd2;
   localparam logic [1:0] OP_STOP  = 2'd3;

   // normalize pass being run
   localparam logic PASS_PATH  = 1'b0;
   localparam logic PASS_DELTA = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD0,
      ST_LD0,
      ST_SEG,
      ST_RDA,
      ST_RDB,
      ST_LATB,
      ST_DOT,
      ST_BLEND,
      ST_SQ,
      ST_ROOT,
      ST_DIV,
      ST_FIN,
      ST_RESP
   } qnp_state_type;

endpackage

// ----- design/qnp_mul.sv -----
module qnp_mul (
   input  logic               clock,
   input  logic signed [31:0] op_a,
   input  logic signed [31:0] op_b,
   output logic signed [63:0] prod
);

   logic signed [63:0] prod_ff;

   // register every product before it is used
   always_ff @(posedge clock) begin
      prod_ff <= 64'(op_a) * 64'(op_b);
   end

   assign prod = prod_ff;

endmodule

// ----- design/qnp_sqrt.sv -----
module qnp_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] res_ff, res_in;
   logic [4:0]  k_ff, k_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [63:0] bit_val;
   logic [63:0] trial;

   // one result bit per cycle, bit weight 4^k from k = 31 down
   always_comb begin
      bit_val = 64'd1 << {k_ff, 1'b0};
      trial   = res_ff + bit_val;
      rem_in  = rem_ff;
      res_in  = res_ff;
      k_in    = k_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start && !run_ff) begin
         rem_in = radicand;
         res_in = '0;
         k_in   = 5'd31;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_val;
         end else begin
            res_in = res_ff >> 1;
         end
         k_in = k_ff - 5'd1;
         if (k_ff == 5'd0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      k_ff   <= k_in;
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

// ----- design/qnp_div.sv -----
module qnp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [46:0] numer,
   input  logic [31:0] denom,
   output logic        done,
   output logic [16:0] quot
);

   logic [31:0] rem_ff, rem_in;
   logic [16:0] low_ff, low_in;
   logic [16:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic [4:0]  k_ff, k_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [32:0] shifted;
   logic        qbit;

   // restoring division, quotient known to stay below 2^17
   always_comb begin
      shifted = {rem_ff, low_ff[16]};
      qbit    = shifted >= {1'b0, den_ff};
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      k_in    = k_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start && !run_ff) begin
         rem_in = 32'(numer[46:17]);
         low_in = numer[16:0];
         quo_in = '0;
         den_in = denom;
         k_in   = 5'd16;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = qbit ? 32'(shifted - {1'b0, den_ff}) : shifted[31:0];
         low_in = {low_ff[15:0], 1'b0};
         quo_in = {quo_ff[15:0], qbit};
         k_in   = k_ff - 5'd1;
         if (k_ff == 5'd0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      k_ff   <= k_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

// ----- design/quaternion_nlerp_path_unit.sv -----
// channel   | ports                                   | handshake
// request   | req_opcode .. req_t_pos                 | start high, busy low
// response  | rsp_cur_w .. rsp_dlt_z                  | rsp_valid, one cycle
// config    | csr_wr_data                             | csr_wr_en
//
// A step runs two normalize passes, each a square root and, for a nonzero
// root, four divides, after the dot product and blend on the one shared
// multiplier. Synchronous reset returns current and delta to identity,
// count to zero. busy stays high through the response cycle; the receiver
// cannot stall.
module quaternion_nlerp_path_unit #(
   parameter int MAX_POINTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [3:0]         req_point_index,
   input  logic signed [15:0] req_in_w,
   input  logic signed [15:0] req_in_x,
   input  logic signed [15:0] req_in_y,
   input  logic signed [15:0] req_in_z,
   input  logic [16:0]        req_t_pos,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_cur_w,
   output logic signed [15:0] rsp_cur_x,
   output logic signed [15:0] rsp_cur_y,
   output logic signed [15:0] rsp_cur_z,
   output logic signed [15:0] rsp_dlt_w,
   output logic signed [15:0] rsp_dlt_x,
   output logic signed [15:0] rsp_dlt_y,
   output logic signed [15:0] rsp_dlt_z,
   input  logic               csr_wr_en,
   input  logic [4:0]         csr_wr_data
);

   import qnp_pkg::*;

   localparam int IW = $clog2(MAX_POINTS);
   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int PW = 17 + NW;

   qnp_state_type state_ff, state_in;

   logic [4:0]          count_ff, count_in;
   logic [3:0]          cnt_ff, cnt_in;
   logic [PW-1:0]       p_ff, p_in;
   logic [IW-1:0]       from_ff, from_in, to_ff, to_in;
   logic [16:0]         local_ff, local_in;
   logic                flip_ff, flip_in;
   logic                with_delta_ff, with_delta_in;
   logic                pass_ff, pass_in;
   logic signed [63:0]  acc_ff, acc_in;
   logic [31:0]         r_ff, r_in;
   logic signed [15:0]  a_ff [4];
   logic signed [15:0]  a_in [4];
   logic signed [15:0]  b_ff [4];
   logic signed [15:0]  b_in [4];
   logic signed [31:0]  v_ff [4];
   logic signed [31:0]  v_in [4];
   logic signed [15:0]  nq_ff [4];
   logic signed [15:0]  nq_in [4];
   logic signed [15:0]  q_ff [4];
   logic signed [15:0]  q_in [4];
   logic signed [15:0]  cur_ff [4];
   logic signed [15:0]  cur_in [4];
   logic signed [15:0]  dlt_ff [4];
   logic signed [15:0]  dlt_in [4];

   logic [63:0]         mem [MAX_POINTS];
   logic [63:0]         rd_data_ff;
   logic [IW-1:0]       rd_addr;

   logic                accept;
   logic                wr_hit;
   logic [16:0]         t_clip;
   logic [NW-1:0]       n_used;
   logic [NW:0]         to_w, from_w;
   logic [PW-1:0]       p_up;

   logic signed [31:0]  op_a, op_b;
   logic signed [63:0]  prod;
   logic signed [63:0]  acc_sum;
   logic                sq_start, sq_done;
   logic [31:0]         root;
   logic                div_start, div_done;
   logic [1:0]          div_idx;
   logic [31:0]         div_den;
   logic [31:0]         div_mag;
   logic [46:0]         div_num;
   logic [16:0]         quot;
   logic [16:0]         quot_sat;
   logic signed [15:0]  quot_res;

   assign accept  = start && (state_ff == ST_IDLE);
   assign wr_hit  = accept && (req_opcode == OP_WRITE) && (32'(req_point_index) < MAX_POINTS);
   assign t_clip  = (req_t_pos > TOne) ? TOne : req_t_pos;
   assign n_used  = (32'(count_ff) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(count_ff);
   assign acc_sum = acc_ff + prod;

   // segment: to = ceil(p / 2^16), never below one
   assign p_up   = p_ff + PW'(65535);
   assign to_w   = (p_up[PW-1:16] == '0) ? (NW+1)'(1) : p_up[PW-1:16];
   assign from_w = to_w - (NW+1)'(1);

   // divider feed: |v| * 2^15 + r / 2
   assign div_idx = (state_ff == ST_ROOT) ? 2'd0 : 2'(cnt_ff + 4'd1);
   assign div_den = (state_ff == ST_ROOT) ? root : r_ff;
   assign div_mag = v_ff[div_idx][31] ? 32'(-v_ff[div_idx]) : 32'(v_ff[div_idx]);
   assign div_num = (47'(div_mag) << 15) + 47'(div_den >> 1);

   // saturate the finished quotient into Q1.15
   always_comb begin
      if (v_ff[cnt_ff[1:0]][31]) begin
         quot_sat = (quot > 17'd32768) ? 17'd32768 : quot;
         quot_res = 16'(-quot_sat);
      end else begin
         quot_sat = (quot > 17'd32767) ? 17'd32767 : quot;
         quot_res = 16'(quot_sat);
      end
   end

   // shared multiplier operand select
   always_comb begin
      logic [1:0] ci;
      ci   = cnt_ff[2:1];
      op_a = '0;
      op_b = '0;
      case (state_ff)
         ST_DOT: begin
            op_a = 32'(a_ff[cnt_ff[1:0]]);
            op_b = 32'(b_ff[cnt_ff[1:0]]);
         end
         ST_BLEND: begin
            if (!cnt_ff[0]) begin
               op_a = 32'(a_ff[ci]);
               op_b = 32'sd65536 - signed'(32'(local_ff));
            end else begin
               op_a = flip_ff ? -32'(b_ff[ci]) : 32'(b_ff[ci]);
               op_b = signed'(32'(local_ff));
            end
         end
         ST_SQ: begin
            op_a = v_ff[cnt_ff[1:0]];
            op_b = v_ff[cnt_ff[1:0]];
         end
         default: ;
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_RDA:  rd_addr = from_ff;
         ST_RDB:  rd_addr = to_ff;
         default: rd_addr = '0;
      endcase
   end

   assign sq_start  = (state_ff == ST_SQ) && (cnt_ff == 4'd4);
   assign div_start = ((state_ff == ST_ROOT) && sq_done && (root != '0)) ||
                      ((state_ff == ST_DIV) && div_done && (cnt_ff != 4'd3));

   qnp_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   qnp_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (unsigned'(acc_sum)),
      .done     (sq_done),
      .root     (root)
   );

   qnp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (div_den),
      .done  (div_done),
      .quot  (quot)
   );

   // sequencer: next state and datapath updates
   always_comb begin
      logic [3:0]         j;
      logic signed [63:0] bl;
      logic signed [63:0] bl_adj;
      j             = cnt_ff - 4'd1;
      bl            = acc_ff + prod;
      bl_adj        = bl + {63'd0, bl[63]};
      state_in      = state_ff;
      count_in      = csr_wr_en ? csr_wr_data : count_ff;
      cnt_in        = cnt_ff;
      p_in          = p_ff;
      from_in       = from_ff;
      to_in         = to_ff;
      local_in      = local_ff;
      flip_in       = flip_ff;
      with_delta_in = with_delta_ff;
      pass_in       = pass_ff;
      acc_in        = acc_ff;
      r_in          = r_ff;
      for (int i = 0; i < 4; i++) begin
         a_in[i]   = a_ff[i];
         b_in[i]   = b_ff[i];
         v_in[i]   = v_ff[i];
         nq_in[i]  = nq_ff[i];
         q_in[i]   = q_ff[i];
         cur_in[i] = cur_ff[i];
         dlt_in[i] = dlt_ff[i];
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pass_in = PASS_PATH;
               case (req_opcode)
                  OP_WRITE: state_in = ST_RESP;
                  OP_START: state_in = (n_used != '0) ? ST_RD0 : ST_RESP;
                  OP_STEP: begin
                     if (n_used >= NW'(2)) begin
                        p_in          = PW'(t_clip) * PW'(n_used - NW'(1));
                        with_delta_in = 1'b1;
                        state_in      = ST_SEG;
                     end else begin
                        state_in = ST_RESP;
                     end
                  end
                  default: begin
                     // stop: back to the path's beginning, or to identity with one point
                     state_in = ST_RESP;
                     if (n_used != '0) begin
                        dlt_in = '{IdentW, 16'sd0, 16'sd0, 16'sd0};
                     end
                     if (n_used == NW'(1)) begin
                        cur_in = '{IdentW, 16'sd0, 16'sd0, 16'sd0};
                     end else if (n_used >= NW'(2)) begin
                        p_in          = '0;
                        with_delta_in = 1'b0;
                        state_in      = ST_SEG;
                     end
                  end
               endcase
            end
         end
         ST_RD0: state_in = ST_LD0;
         ST_LD0: begin
            cur_in[0] = rd_data_ff[63:48];
            cur_in[1] = rd_data_ff[47:32];
            cur_in[2] = rd_data_ff[31:16];
            cur_in[3] = rd_data_ff[15:0];
            state_in  = ST_RESP;
         end
         ST_SEG: begin
            to_in    = IW'(to_w);
            from_in  = IW'(from_w);
            local_in = 17'(p_ff - (PW'(from_w) << 16));
            state_in = ST_RDA;
         end
         ST_RDA: state_in = ST_RDB;
         ST_RDB: begin
            a_in[0]  = rd_data_ff[63:48];
            a_in[1]  = rd_data_ff[47:32];
            a_in[2]  = rd_data_ff[31:16];
            a_in[3]  = rd_data_ff[15:0];
            state_in = ST_LATB;
         end
         ST_LATB: begin
            b_in[0]  = rd_data_ff[63:48];
            b_in[1]  = rd_data_ff[47:32];
            b_in[2]  = rd_data_ff[31:16];
            b_in[3]  = rd_data_ff[15:0];
            cnt_in   = '0;
            acc_in   = '0;
            state_in = ST_DOT;
         end
         ST_DOT: begin
            // accumulate the dot product one term a cycle
            if (cnt_ff != '0) begin
               acc_in = acc_sum;
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd4) begin
               flip_in  = acc_sum[63];
               cnt_in   = '0;
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            // two products per component, then halve toward zero
            if (cnt_ff != '0) begin
               if (!j[0]) begin
                  acc_in = prod;
               end else begin
                  v_in[j[2:1]] = bl_adj[32:1];
               end
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd8) begin
               cnt_in   = '0;
               acc_in   = '0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            if (cnt_ff != '0) begin
               acc_in = acc_sum;
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd4) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (sq_done) begin
               r_in   = root;
               cnt_in = '0;
               if (root == '0) begin
                  nq_in    = '{IdentW, 16'sd0, 16'sd0, 16'sd0};
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               nq_in[cnt_ff[1:0]] = quot_res;
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == 4'd3) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            if (pass_ff == PASS_PATH) begin
               if (with_delta_ff) begin
                  // second pass: normalize old current plus new
                  for (int i = 0; i < 4; i++) begin
                     q_in[i] = nq_ff[i];
                     v_in[i] = (32'(cur_ff[i]) + 32'(nq_ff[i])) <<< 14;
                  end
                  pass_in  = PASS_DELTA;
                  cnt_in   = '0;
                  acc_in   = '0;
                  state_in = ST_SQ;
               end else begin
                  cur_in   = nq_ff;
                  state_in = ST_RESP;
               end
            end else begin
               dlt_in   = nq_ff;
               cur_in   = q_ff;
               state_in = ST_RESP;
            end
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         cnt_ff        <= '0;
         with_delta_ff <= 1'b0;
         pass_ff       <= PASS_PATH;
         cur_ff        <= '{IdentW, 16'sd0, 16'sd0, 16'sd0};
         dlt_ff        <= '{IdentW, 16'sd0, 16'sd0, 16'sd0};
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         cnt_ff        <= cnt_in;
         with_delta_ff <= with_delta_in;
         pass_ff       <= pass_in;
         cur_ff        <= cur_in;
         dlt_ff        <= dlt_in;
      end
      p_ff     <= p_in;
      from_ff  <= from_in;
      to_ff    <= to_in;
      local_ff <= local_in;
      flip_ff  <= flip_in;
      acc_ff   <= acc_in;
      r_ff     <= r_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      v_ff     <= v_in;
      nq_ff    <= nq_in;
      q_ff     <= q_in;
   end

   // control point table, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_hit) begin
         mem[IW'(req_point_index)] <= {req_in_w, req_in_x, req_in_y, req_in_z};
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_cur_w = cur_ff[0];
   assign rsp_cur_x = cur_ff[1];
   assign rsp_cur_y = cur_ff[2];
   assign rsp_cur_z = cur_ff[3];
   assign rsp_dlt_w = dlt_ff[0];
   assign rsp_dlt_x = dlt_ff[1];
   assign rsp_dlt_y = dlt_ff[2];
   assign rsp_dlt_z = dlt_ff[3];

endmodule

// ----- design/qnp_chk.sv -----
module qnp_chk (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // an accepted request keeps the unit busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but unit not busy");

   // a response only comes from a request in flight
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response while idle");

   // one response per request, then ready again
   a_rsp_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("response repeated or unit stuck busy");

   // no response while a new request is taken
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> !rsp_valid)
      else $error("response and request in the same cycle");

endmodule

bind quaternion_nlerp_path_unit qnp_chk u_qnp_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
